// ===== sv/ess_pkg.sv =====
// ----------------------------------------------------------------------------
// ess_pkg
// shared types, codes and pattern tables of the escape sequence stuffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ess_pkg;

    // opcodes of an input item
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_MARK = 2'd1;
    localparam logic [1:0] OP_EOS  = 2'd2;

    // kinds of a result item
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_MARK = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // escaped data type code and highest legal mark code
    localparam logic [3:0] MARK_X   = 4'd0;
    localparam logic [3:0] MARK_MAX = 4'd12;

    // configuration register indexes
    localparam logic CFG_IDX_DECODE = 1'b0;
    localparam logic CFG_IDX_LEAD   = 1'b1;

    localparam logic [7:0] LEAD_RESET = 8'hAD;
    localparam logic [7:0] CHAR_X     = 8'h58;

    localparam int PAT_LEN        = 5;
    localparam int ESS_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [3:0] mark_kind;
    } t_ess_in;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [3:0] out_mark;
        logic       last;
    } t_ess_out;

    typedef struct packed {
        logic       decode_mode;
        logic [7:0] lead_byte;
    } t_ess_cfg;

    // one literal result, emitted after the pattern bytes of a command
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] lit_byte;
        logic [3:0] mark;
    } t_ess_lit;

    // work handed from front to back: pat_cnt pattern bytes, then lit_cnt literals
    typedef struct packed {
        logic [2:0] pat_cnt;
        logic [1:0] lit_cnt;
        t_ess_lit   lit0;
        t_ess_lit   lit1;
    } t_ess_cmd;

    function automatic logic [7:0] pat_byte(input logic [2:0] idx, input logic [7:0] lead);
        logic [7:0] res;
        unique case (idx)
            3'd0:    res = lead;
            3'd1:    res = 8'hFD;
            3'd2:    res = 8'hEA;
            3'd3:    res = 8'h77;
            3'd4:    res = 8'h21;
            default: res = 8'h00;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] mark_char(input logic [3:0] k);
        logic [7:0] res;
        unique case (k)
            4'd0:    res = 8'h58; // X
            4'd1:    res = 8'h46; // F
            4'd2:    res = 8'h45; // E
            4'd3:    res = 8'h43; // C
            4'd4:    res = 8'h44; // D
            4'd5:    res = 8'h52; // R
            4'd6:    res = 8'h72; // r
            4'd7:    res = 8'h57; // W
            4'd8:    res = 8'h49; // I
            4'd9:    res = 8'h21; // !
            4'd10:   res = 8'h53; // S
            4'd11:   res = 8'h73; // s
            4'd12:   res = 8'h64; // d
            default: res = 8'h00;
        endcase
        return res;
    endfunction

    // {found, code} of a type character
    function automatic logic [4:0] char_code(input logic [7:0] c);
        logic [4:0] res;
        unique case (c)
            8'h58:   res = {1'b1, 4'd0};
            8'h46:   res = {1'b1, 4'd1};
            8'h45:   res = {1'b1, 4'd2};
            8'h43:   res = {1'b1, 4'd3};
            8'h44:   res = {1'b1, 4'd4};
            8'h52:   res = {1'b1, 4'd5};
            8'h72:   res = {1'b1, 4'd6};
            8'h57:   res = {1'b1, 4'd7};
            8'h49:   res = {1'b1, 4'd8};
            8'h21:   res = {1'b1, 4'd9};
            8'h53:   res = {1'b1, 4'd10};
            8'h73:   res = {1'b1, 4'd11};
            8'h64:   res = {1'b1, 4'd12};
            default: res = 5'd0;
        endcase
        return res;
    endfunction

    // length of the longest active partial match
    function automatic logic [2:0] match_len(input logic [4:0] f);
        logic [2:0] res;
        priority if (f[4]) res = 3'd5;
        else if (f[3])     res = 3'd4;
        else if (f[2])     res = 3'd3;
        else if (f[1])     res = 3'd2;
        else if (f[0])     res = 3'd1;
        else               res = 3'd0;
        return res;
    endfunction

    // shift-and step of the matcher
    function automatic logic [4:0] advance(input logic [4:0] f, input logic [7:0] b,
                                           input logic [7:0] lead);
        logic [4:0] eq;
        for (int i = 0; i < PAT_LEN; i++) begin
            eq[i] = (pat_byte(3'(i), lead) == b);
        end
        return {f[3:0], 1'b1} & eq;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ess_front.sv =====
// ----------------------------------------------------------------------------
// ess_front
// matcher state and classification of each accepted item into a command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ess_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ess_pkg::t_ess_cfg i_cfg,
    input  wire logic             i_accept,
    input  wire ess_pkg::t_ess_in  i_item,
    output logic                  o_cmd_valid,
    output ess_pkg::t_ess_cmd     o_cmd
);
    import ess_pkg::*;

    logic [4:0] r_flags;
    logic [4:0] n_flags;
    logic [4:0] nf;
    logic [4:0] ck;
    logic [2:0] old_len;
    logic [2:0] new_len;
    logic [2:0] rel;
    t_ess_lit   lit_b;
    t_ess_lit   lit_err;

    always_comb begin
        old_len = match_len(r_flags);
        nf      = advance(r_flags, i_item.data_byte, i_cfg.lead_byte);
        new_len = match_len(nf);
        rel     = old_len + 3'd1 - new_len;
        ck      = char_code(i_item.data_byte);
        lit_b   = '{kind: KIND_BYTE, lit_byte: i_item.data_byte, mark: 4'd0};
        lit_err = '{kind: KIND_ERR, lit_byte: 8'd0, mark: 4'd0};

        n_flags     = r_flags;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;

        if (i_accept) begin
            unique case (i_item.opcode)
                OP_DATA: begin
                    o_cmd_valid = 1'b1;
                    if (!i_cfg.decode_mode) begin
                        o_cmd.lit_cnt = 2'd1;
                        o_cmd.lit0    = lit_b;
                        n_flags       = nf;
                        if (nf[4]) begin
                            o_cmd.lit_cnt = 2'd2;
                            o_cmd.lit1    = '{kind: KIND_BYTE, lit_byte: CHAR_X, mark: 4'd0};
                            n_flags       = 5'd0;
                        end
                    end else if (r_flags[4]) begin
                        // full pattern held: type character decides
                        n_flags = 5'd0;
                        if (ck[4] && ck[3:0] == MARK_X) begin
                            o_cmd.pat_cnt = 3'(PAT_LEN);
                        end else if (ck[4]) begin
                            o_cmd.lit_cnt = 2'd1;
                            o_cmd.lit0    = '{kind: KIND_MARK, lit_byte: 8'd0, mark: ck[3:0]};
                        end else begin
                            o_cmd.lit_cnt = 2'd1;
                            o_cmd.lit0    = lit_err;
                        end
                    end else begin
                        // release what can no longer begin a match
                        n_flags = nf;
                        if (new_len == 3'd0) begin
                            o_cmd.pat_cnt = old_len;
                            o_cmd.lit_cnt = 2'd1;
                            o_cmd.lit0    = lit_b;
                        end else begin
                            o_cmd.pat_cnt = rel;
                            o_cmd_valid   = (rel != 3'd0);
                        end
                    end
                end
                OP_MARK: begin
                    if (!i_cfg.decode_mode) begin
                        o_cmd_valid = 1'b1;
                        if (i_item.mark_kind == MARK_X || i_item.mark_kind > MARK_MAX) begin
                            o_cmd.lit_cnt = 2'd1;
                            o_cmd.lit0    = lit_err;
                        end else begin
                            o_cmd.pat_cnt = 3'(PAT_LEN);
                            o_cmd.lit_cnt = 2'd1;
                            o_cmd.lit0    = '{kind: KIND_BYTE,
                                              lit_byte: mark_char(i_item.mark_kind),
                                              mark: 4'd0};
                            n_flags       = 5'd0;
                        end
                    end
                end
                OP_EOS: begin
                    n_flags = 5'd0;
                    if (i_cfg.decode_mode && old_len != 3'd0) begin
                        o_cmd_valid   = 1'b1;
                        o_cmd.pat_cnt = old_len;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= 5'd0;
        end else begin
            r_flags <= n_flags;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ess_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ess_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ess_cmd_fifo #(
    parameter int DEPTH = ess_pkg::ESS_FIFO_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ess_pkg::t_ess_cmd i_cmd,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output ess_pkg::t_ess_cmd      o_cmd
);
    import ess_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_ess_cmd        r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;

    always_comb begin
        n_wr  = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd  = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        n_cnt = r_cnt + CW'(i_push) - CW'(i_pop);
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= n_wr;
            if (i_pop)  r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("command queue over depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("push into full command queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("pop from empty command queue");

endmodule

`default_nettype wire

// ===== sv/ess_back.sv =====
// ----------------------------------------------------------------------------
// ess_back
// expands commands into output register items, one per cycle unless pop stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ess_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ess_pkg::t_ess_cfg i_cfg,
    input  wire logic              i_cmd_valid,
    input  wire ess_pkg::t_ess_cmd i_cmd,
    output logic                   o_cmd_pop,
    input  wire logic              i_out_pop,
    output logic                   o_out_valid,
    output ess_pkg::t_ess_out      o_out
);
    import ess_pkg::*;

    logic [2:0] r_idx;
    logic [2:0] total;
    logic       load;
    logic       at_end;
    t_ess_lit   lit;
    t_ess_out   n_out;
    logic       r_out_valid;
    t_ess_out   r_out;

    always_comb begin
        total  = i_cmd.pat_cnt + {1'b0, i_cmd.lit_cnt};
        load   = i_cmd_valid && (!r_out_valid || i_out_pop);
        at_end = (r_idx == total - 3'd1);
        lit    = (r_idx == i_cmd.pat_cnt) ? i_cmd.lit0 : i_cmd.lit1;
        if (r_idx < i_cmd.pat_cnt) begin
            n_out.out_kind = KIND_BYTE;
            n_out.out_byte = pat_byte(r_idx, i_cfg.lead_byte);
            n_out.out_mark = 4'd0;
        end else begin
            n_out.out_kind = lit.kind;
            n_out.out_byte = lit.lit_byte;
            n_out.out_mark = lit.mark;
        end
        n_out.last = at_end;
    end

    assign o_cmd_pop   = load && at_end;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= at_end ? 3'd0 : r_idx + 3'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> (r_idx < total)) else $error("expansion index past command end");

endmodule

`default_nettype wire

// ===== sv/escape_sequence_stuffer_unit.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_stuffer_unit
// escape marker stream codec: stuffing and mark insertion, unstuffing and mark
// detection around a five-byte pattern with a configurable lead byte
// ----------------------------------------------------------------------------
// the first result of an item is registered in the command queue and then in
//   the output register before it reaches the result ports
// throughput: one item per cycle accepted while the command queue has room;
//   results leave at one per cycle while pop is held, set by the single
//   output register, so an item's n results hold the back end until they leave
// reset: synchronous active low; clears matcher, queue, output and config
//   (encode mode, lead byte 0xad); no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_stuffer_unit #(
    parameter int FIFO_DEPTH = ess_pkg::ESS_FIFO_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration write port
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [7:0]       i_cfg_data,
    // input queue side
    input  wire logic             push,
    output logic                  full,
    input  wire ess_pkg::t_ess_in i_item,
    // result queue side
    output logic                  empty,
    input  wire logic             pop,
    output ess_pkg::t_ess_out     o_item
);
    import ess_pkg::*;

    // configuration registers
    t_ess_cfg r_cfg;

    // front to queue
    logic     accept;
    logic     front_valid;
    t_ess_cmd front_cmd;

    // queue to back
    logic     q_full;
    logic     q_valid;
    t_ess_cmd q_cmd;
    logic     q_pop;

    logic     out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decode_mode <= 1'b0;
            r_cfg.lead_byte   <= LEAD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_DECODE: r_cfg.decode_mode <= i_cfg_data[0];
                CFG_IDX_LEAD:   r_cfg.lead_byte   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // an item is taken whenever the queue can hold its command
    assign accept = push && !q_full;
    assign full   = q_full;

    // front: matcher and classification
    ess_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd)
    );

    // decoupling queue, items that cause no result push nothing
    ess_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back: result expansion and output register
    ess_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_out_pop   (pop),
        .o_out_valid (out_valid),
        .o_out       (o_item)
    );

    assign empty = !out_valid;

    // commands are only made for accepted items
    a_cmd_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_valid |-> accept) else $error("command without accepted item");
    // a command leaving the queue always leaves a result in the output register
    a_pop_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !empty) else $error("queue popped without a result loaded");

endmodule

`default_nettype wire

// ===== bench/tb_escape_sequence_stuffer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_escape_sequence_stuffer_unit
// self-checking bench for the escape sequence stuffer: a queue-fed driver and
// a clocked monitor check every result item against an in-bench predictor,
// across encode and decode phases with several lead bytes and random stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_escape_sequence_stuffer_unit;

    import ess_pkg::*;

    localparam int          CLK_PERIOD = 8;
    localparam int unsigned CYC_LIMIT  = 500000;
    localparam int unsigned RAND_ITEMS = 310;
    localparam int          MAX_GAP    = 17;
    // no opcode of its own in the package; the block must ignore it
    localparam logic [1:0]  OP_UNDEF   = 2'd3;

    // pattern bytes after the lead byte, first one in the top byte
    localparam logic [31:0]   PAT_TAIL   = 32'hFDEA7721;
    // type characters in code order, code 0 in the top byte
    localparam logic [103:0]  TYPE_CHARS = "XFECDRrWI!Ssd";

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       push        = 1'b0;
    logic       full;
    t_ess_in    i_item      = '0;
    logic       empty;
    logic       pop         = 1'b0;
    t_ess_out   o_item;

    escape_sequence_stuffer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_ess_in     stim_q [$];      // items waiting for the driver
    t_ess_out    codec_out_q [$]; // predicted result items, oldest first

    // predictor copy of registers and matcher
    logic        cfg_decode = 1'b0;
    logic [7:0]  cfg_lead   = LEAD_RESET;
    logic [4:0]  hold_flags = 5'd0;

    int unsigned cyc        = 0;
    int unsigned last_move  = 0;
    int unsigned n_enq      = 0;  // items handed to the driver
    int unsigned n_acc      = 0;  // items accepted by the block
    int unsigned n_useful   = 0;  // queued items the block does not ignore
    int unsigned n_checked  = 0;
    int unsigned n_marks    = 0;
    int unsigned n_errs     = 0;
    int unsigned n_settings = 1;
    int unsigned n_fail     = 0;

    bit          in_taken   = 1'b0;
    bit          out_taken  = 1'b0;
    bit          hold_tx    = 1'b0;
    bit          tx_calm    = 1'b0;
    bit          rx_calm    = 1'b0;
    int unsigned tx_wait    = 0;
    int unsigned rx_wait    = 0;

    // ------------------------------------------------------------------------
    // predictor helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pat_at(input int unsigned j);
        if (j == 0)
            return cfg_lead;
        return PAT_TAIL[8 * (4 - j) +: 8];
    endfunction

    function automatic logic [7:0] type_char(input logic [3:0] k);
        return TYPE_CHARS[8 * (12 - k) +: 8];
    endfunction

    // code of a type character, -1 when it is none
    function automatic int type_code(input logic [7:0] c);
        int k;
        k = -1;
        for (int j = 12; j >= 0; j--)
            if (TYPE_CHARS[8 * (12 - j) +: 8] == c)
                k = j;
        return k;
    endfunction

    // shift-and step: bit j means the last j+1 bytes equal the pattern head
    function automatic logic [4:0] step_flags(input logic [4:0] f, input logic [7:0] b);
        logic [4:0] hit;
        hit = 5'd0;
        for (int j = 0; j < PAT_LEN; j++)
            if (pat_at(j) == b)
                hit[j] = 1'b1;
        return {f[3:0], 1'b1} & hit;
    endfunction

    function automatic int unsigned run_len(input logic [4:0] f);
        int unsigned len;
        len = 0;
        for (int j = 0; j < PAT_LEN; j++)
            if (f[j])
                len = j + 1;
        return len;
    endfunction

    function automatic void expect_out(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [3:0] m);
        t_ess_out r;
        r.out_kind = kind;
        r.out_byte = b;
        r.out_mark = m;
        r.last     = 1'b0;
        codec_out_q.push_back(r);
    endfunction

    // work out the result items of one accepted item
    function automatic void predict_codec_out(input t_ess_in it);
        int unsigned n0;
        int unsigned old_len;
        int unsigned new_len;
        int          k;
        logic [4:0]  nf;
        t_ess_out    r;
        n0 = codec_out_q.size();
        case (it.opcode)
            OP_DATA: begin
                if (!cfg_decode) begin
                    // stuffing: byte goes straight out, X after a full pattern
                    nf = step_flags(hold_flags, it.data_byte);
                    expect_out(KIND_BYTE, it.data_byte, 4'd0);
                    if (nf[4]) begin
                        expect_out(KIND_BYTE, CHAR_X, 4'd0);
                        nf = 5'd0;
                    end
                    hold_flags = nf;
                end else if (hold_flags[4]) begin
                    // type character after a held pattern
                    k = type_code(it.data_byte);
                    if (k == 0) begin
                        for (int j = 0; j < PAT_LEN; j++)
                            expect_out(KIND_BYTE, pat_at(j), 4'd0);
                    end else if (k > 0) begin
                        expect_out(KIND_MARK, 8'd0, 4'(k));
                    end else begin
                        expect_out(KIND_ERR, 8'd0, 4'd0);
                    end
                    hold_flags = 5'd0;
                end else begin
                    // release whatever can no longer start a pattern
                    old_len = run_len(hold_flags);
                    nf      = step_flags(hold_flags, it.data_byte);
                    new_len = run_len(nf);
                    for (int unsigned j = 0; j < old_len + 1 - new_len; j++)
                        expect_out(KIND_BYTE, (j < old_len) ? pat_at(j) : it.data_byte, 4'd0);
                    hold_flags = nf;
                end
            end
            OP_MARK: begin
                if (!cfg_decode) begin
                    if (it.mark_kind == MARK_X || it.mark_kind > MARK_MAX) begin
                        expect_out(KIND_ERR, 8'd0, 4'd0);
                    end else begin
                        for (int j = 0; j < PAT_LEN; j++)
                            expect_out(KIND_BYTE, pat_at(j), 4'd0);
                        expect_out(KIND_BYTE, type_char(it.mark_kind), 4'd0);
                        hold_flags = 5'd0;
                    end
                end
            end
            OP_EOS: begin
                if (cfg_decode)
                    for (int unsigned j = 0; j < run_len(hold_flags); j++)
                        expect_out(KIND_BYTE, pat_at(j), 4'd0);
                hold_flags = 5'd0;
            end
            default: ;
        endcase
        if (codec_out_q.size() > n0) begin
            r      = codec_out_q.pop_back();
            r.last = 1'b1;
            codec_out_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        if (n_fail < 40)
            $display("[%0d] mismatch at result %0d: %s", cyc, n_checked, msg);
        n_fail++;
    endtask

    task automatic check_result(input t_ess_out got);
        t_ess_out want;
        if (codec_out_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected item kind=%0d byte=%02h mark=%0d last=%0b",
                                    got.out_kind, got.out_byte, got.out_mark, got.last));
            return;
        end
        want = codec_out_q.pop_front();
        if (want.out_kind == KIND_MARK) n_marks++;
        if (want.out_kind == KIND_ERR)  n_errs++;
        if (got.out_kind !== want.out_kind)
            flag_mismatch($sformatf("out_kind %0d, want %0d", got.out_kind, want.out_kind));
        if (got.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.out_mark !== want.out_mark)
            flag_mismatch($sformatf("out_mark %0d, want %0d", got.out_mark, want.out_mark));
        if (got.last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        n_checked++;
    endtask

    // ------------------------------------------------------------------------
    // sampling at the rising edge: accepted items feed the predictor,
    // accepted results are checked, and the cycle limit is watched
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cyc, codec_out_q.size());
            $display("== FAIL ==");
            $finish;
        end
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (i_rst_n) begin
            if (push && !full) begin
                predict_codec_out(i_item);
                n_acc++;
                in_taken  = 1'b1;
                last_move = cyc;
            end
            if (pop && !empty) begin
                check_result(o_item);
                out_taken = 1'b1;
                last_move = cyc;
            end
        end
    end

    function automatic int unsigned draw_gap(input bit calm);
        if (calm)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, MAX_GAP);
        return $urandom_range(0, 2);
    endfunction

    // ------------------------------------------------------------------------
    // input driver: falling edge, one item in flight, random gap after each
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : item_driver
        t_ess_in nxt;
        bit      push_nxt;
        if (i_rst_n && (!push || in_taken)) begin
            if (push && in_taken) begin
                // quiet stretches with no gaps now and then
                if ($urandom_range(0, 24) == 0)
                    tx_calm = !tx_calm;
                tx_wait = draw_gap(tx_calm);
            end
            push_nxt = 1'b0;
            if (tx_wait > 0) begin
                tx_wait--;
            end else if (stim_q.size() != 0 && !hold_tx) begin
                nxt      = stim_q.pop_front();
                i_item  <= nxt;
                push_nxt = 1'b1;
            end
            push <= push_nxt;
        end
    end

    // ------------------------------------------------------------------------
    // result side: pop held high, dropped for a random stall after each item
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                if ($urandom_range(0, 24) == 0)
                    rx_calm = !rx_calm;
                rx_wait = draw_gap(rx_calm);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_ess_in make_item(input logic [1:0] op, input logic [7:0] b,
                                          input logic [3:0] k);
        t_ess_in it;
        it.opcode    = op;
        it.data_byte = b;
        it.mark_kind = k;
        return it;
    endfunction

    task automatic queue_item(input t_ess_in it);
        stim_q.push_back(it);
        n_enq++;
        if (!(it.opcode == OP_UNDEF || (it.opcode == OP_MARK && cfg_decode)))
            n_useful++;
    endtask

    // data byte with unused mark bits randomized
    task automatic queue_byte(input logic [7:0] b);
        queue_item(make_item(OP_DATA, b, 4'($urandom_range(0, 15))));
    endtask

    task automatic queue_mark(input logic [3:0] k);
        queue_item(make_item(OP_MARK, 8'($urandom_range(0, 255)), k));
    endtask

    task automatic queue_eos();
        queue_item(make_item(OP_EOS, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
    endtask

    // one random fragment of the stream, mostly pattern-shaped
    task automatic add_burst();
        int unsigned sel;
        int unsigned plen;
        sel = $urandom_range(0, 15);
        if (sel < 4) begin
            queue_byte(8'($urandom_range(0, 255)));
        end else if (sel < 6) begin
            queue_byte(pat_at($urandom_range(0, 4)));
        end else if (sel < 10) begin
            // whole pattern and the byte after it
            for (int j = 0; j < PAT_LEN; j++)
                queue_byte(pat_at(j));
            case ($urandom_range(0, 3))
                0, 1:    queue_byte(CHAR_X);
                2:       queue_byte(type_char(4'($urandom_range(1, 12))));
                default: queue_byte(8'($urandom_range(0, 255)));
            endcase
        end else if (sel < 12) begin
            // broken pattern: a prefix then a byte that may or may not fit
            plen = $urandom_range(1, 4);
            for (int unsigned j = 0; j < plen; j++)
                queue_byte(pat_at(j));
            if ($urandom_range(0, 1) == 0)
                queue_byte(8'($urandom_range(0, 255)));
            else
                queue_byte(pat_at($urandom_range(0, 4)));
        end else if (sel < 14) begin
            if ($urandom_range(0, 3) == 0)
                queue_mark(4'($urandom_range(0, 15)));
            else
                queue_mark(4'($urandom_range(1, 12)));
        end else if (sel == 14) begin
            queue_eos();
        end else begin
            queue_item(make_item(OP_UNDEF, 8'($urandom_range(0, 255)),
                                 4'($urandom_range(0, 15))));
        end
    endtask

    // register write, only while nothing is in flight
    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_IDX_DECODE)
            cfg_decode = val[0];
        else
            cfg_lead = val;
    endtask

    // all queued items accepted, all results back, pipeline given time to settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (n_acc != n_enq || codec_out_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned rand_base;
        int unsigned ph;
        int unsigned ph_start;
        int unsigned ph_len;
        logic [7:0]  lead;
        logic        dec;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, encode with the reset lead byte
        @(posedge i_clk);
        queue_item(make_item(OP_DATA, 8'h00, 4'd0));
        queue_item(make_item(OP_DATA, 8'hFF, 4'd15));
        for (int j = 0; j < PAT_LEN; j++)
            queue_byte(pat_at(j));          // full pattern gets an X stuffed
        queue_byte(LEAD_RESET);             // partial match, then cleared by a mark
        queue_item(make_item(OP_MARK, 8'hFF, 4'd1));
        queue_mark(MARK_MAX);
        queue_mark(MARK_X);                 // forbidden data type
        queue_mark(4'd15);                  // unknown type
        queue_byte(8'hFD);
        queue_eos();
        queue_item(make_item(OP_UNDEF, 8'hFF, 4'd15));
        wait_idle();

        // directed, decode
        write_reg(CFG_IDX_DECODE, 8'd1);
        n_settings++;
        @(posedge i_clk);
        for (int j = 0; j < PAT_LEN; j++)
            queue_byte(pat_at(j));
        queue_byte(CHAR_X);                 // escaped pattern comes back as data
        queue_mark(4'd3);                   // mark request while decoding
        queue_byte(pat_at(0));
        queue_byte(pat_at(1));              // held across the lead byte change
        wait_idle();
        write_reg(CFG_IDX_LEAD, 8'h00);
        n_settings++;
        @(posedge i_clk);
        queue_eos();                        // releases held bytes against new lead
        wait_idle();

        // random phases over several register settings
        rand_base = n_useful;
        ph = 0;
        while (n_useful - rand_base < RAND_ITEMS) begin
            case (ph)
                0:       lead = LEAD_RESET;
                1:       lead = 8'hFF;
                2:       lead = 8'h00;
                3:       lead = 8'h21;      // overlaps the last pattern byte
                4:       lead = 8'hFD;
                5:       lead = CHAR_X;
                6:       lead = 8'h77;
                default: lead = 8'($urandom_range(0, 255));
            endcase
            dec = (ph % 2 == 0) ^ ((ph > 5) && ($urandom_range(0, 2) == 0));
            write_reg(CFG_IDX_DECODE, {7'd0, dec});
            write_reg(CFG_IDX_LEAD, lead);
            n_settings++;

            @(posedge i_clk);
            ph_start = n_enq;
            ph_len   = $urandom_range(25, 45);
            while (n_enq - ph_start < ph_len)
                add_burst();

            if (ph == 3) begin
                // sender holds off mid-phase until the result side is drained
                do @(negedge i_clk);
                while (n_acc < ph_start + 10);
                @(posedge i_clk);
                hold_tx = 1'b1;
                do @(negedge i_clk);
                while (push || codec_out_q.size() != 0);
                @(posedge i_clk);
                hold_tx = 1'b0;
            end
            wait_idle();
            ph++;
        end

        // end of run: wait for progress to stop, then settle
        do @(negedge i_clk);
        while ((n_acc != n_enq || codec_out_q.size() != 0) && (cyc - last_move) < 2000);
        repeat (20) @(negedge i_clk);
        if (n_acc != n_enq)
            flag_mismatch($sformatf("%0d items never accepted", n_enq - n_acc));
        if (codec_out_q.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    codec_out_q.size()));

        $display("ran %0d items (%0d not ignored) over %0d register settings in %0d cycles",
                 n_acc, n_useful, n_settings, cyc);
        $display("checked %0d results: %0d mark events, %0d errors; %0d mismatches",
                 n_checked, n_marks, n_errs, n_fail);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ess_pkg.sv
sv/ess_front.sv
sv/ess_cmd_fifo.sv
sv/ess_back.sv
sv/escape_sequence_stuffer_unit.sv
bench/tb_escape_sequence_stuffer_unit.sv
